@@ rtl/btm_pkg.sv @@
// btm_pkg: shared constants for the binary template match and remove unit.
// Holds field widths, request and register codes, and parameter defaults.
// No dependencies.
package btm_pkg;

    localparam int DEF_MAX_IMAGE_ROWS = 1024;
    localparam int DEF_MAX_IMAGE_COLS = 1024;
    localparam int DEF_MAX_LOGO_ROWS  = 64;
    localparam int DEF_MAX_LOGO_COLS  = 64;

    // position arithmetic: start (10b) plus count (up to 2047) plus logo size
    localparam int PW = 13;
    // logo offsets and sizes, up to 127
    localparam int LW = 9;
    // score and thresholds
    localparam int SW = 13;

    localparam logic [1:0] REQ_WR_IMAGE = 2'd0;
    localparam logic [1:0] REQ_WR_LOGO  = 2'd1;
    localparam logic [1:0] REQ_SEARCH   = 2'd2;
    localparam logic [1:0] REQ_RD_IMAGE = 2'd3;

    localparam logic [2:0] REG_IMAGE_ROWS   = 3'd0;
    localparam logic [2:0] REG_IMAGE_COLS   = 3'd1;
    localparam logic [2:0] REG_LOGO_ROWS    = 3'd2;
    localparam logic [2:0] REG_LOGO_COLS    = 3'd3;
    localparam logic [2:0] REG_MATCH_CUTOFF = 3'd4;
    localparam logic [2:0] REG_GOOD_ENOUGH  = 3'd5;
    localparam logic [2:0] REG_REMOVAL_MODE = 3'd6;

    localparam logic [10:0] RST_IMAGE_ROWS   = 11'd1024;
    localparam logic [10:0] RST_IMAGE_COLS   = 11'd1024;
    localparam logic [6:0]  RST_LOGO_ROWS    = 7'd64;
    localparam logic [6:0]  RST_LOGO_COLS    = 7'd64;
    localparam logic [12:0] RST_MATCH_CUTOFF = 13'd0;
    localparam logic [12:0] RST_GOOD_ENOUGH  = 13'd150;

endpackage

@@ rtl/binary_template_match_remove_unit.sv @@
// Binary template match and remove unit: image and logo bit stores, search and removal.
// A search scores the logo pixel by pixel at each position, row by row; removal then rewrites
// the image under the best match one logo pixel at a time (single-port reads).
// One word is worked on at a time; the result sits in an output register.
// Reset (rst_n, async low) idles the control, drops out_valid and sets configuration to its
// defaults; store contents stay undefined. Depends on btm_pkg.
module binary_template_match_remove_unit #(
    parameter int MAX_IMAGE_ROWS = btm_pkg::DEF_MAX_IMAGE_ROWS,
    parameter int MAX_IMAGE_COLS = btm_pkg::DEF_MAX_IMAGE_COLS,
    parameter int MAX_LOGO_ROWS  = btm_pkg::DEF_MAX_LOGO_ROWS,
    parameter int MAX_LOGO_COLS  = btm_pkg::DEF_MAX_LOGO_COLS
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [12:0] cfg_data,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [1:0]  req_type,
    input  logic [9:0]  pix_row,
    input  logic [9:0]  pix_col,
    input  logic        pix_value,
    input  logic [9:0]  search_row,
    input  logic [9:0]  search_col,
    input  logic [10:0] search_rows,
    input  logic [10:0] search_cols,
    output logic        out_valid,
    input  logic        out_stall,
    output logic        found,
    output logic [9:0]  match_row,
    output logic [9:0]  match_col,
    output logic [12:0] best_score,
    output logic        read_pixel
);

    localparam int IMG_DEPTH = MAX_IMAGE_ROWS * MAX_IMAGE_COLS;
    localparam int LOGO_DEPTH = MAX_LOGO_ROWS * MAX_LOGO_COLS;
    localparam int IMG_AW = (IMG_DEPTH > 1) ? $clog2(IMG_DEPTH) : 1;
    localparam int LOGO_AW = (LOGO_DEPTH > 1) ? $clog2(LOGO_DEPTH) : 1;
    localparam int PW = btm_pkg::PW;
    localparam int LW = btm_pkg::LW;
    localparam int SW = btm_pkg::SW;

    localparam logic [3:0] ST_IDLE    = 4'd0;
    localparam logic [3:0] ST_EXEC    = 4'd1;
    localparam logic [3:0] ST_RD_WAIT = 4'd2;
    localparam logic [3:0] ST_POS     = 4'd3;
    localparam logic [3:0] ST_SC_RD   = 4'd4;
    localparam logic [3:0] ST_SC_ACC  = 4'd5;
    localparam logic [3:0] ST_RM_RD   = 4'd6;
    localparam logic [3:0] ST_RM_WR   = 4'd7;
    localparam logic [3:0] ST_DONE    = 4'd8;

    logic [10:0] image_rows_reg, image_cols_reg;
    logic [6:0]  logo_rows_reg, logo_ncols_reg;
    logic [12:0] match_cutoff_reg, stop_score_reg;
    logic        removal_mode_reg;

    logic [3:0]  state_reg;
    logic [1:0]  req_reg;
    logic [9:0]  pr_reg, pc_reg;
    logic        pv_reg;
    logic [PW-1:0] r_reg, c_reg, rend_reg, cend_reg, sc_reg;
    logic [LW-1:0] li_reg, lj_reg;
    logic [SW-1:0] s_reg, best_reg;
    logic [9:0]  brow_reg, bcol_reg;
    logic        found_reg, rd_reg, rd_hit_reg;
    logic        search_rows_zero_reg, search_cols_zero_reg;

    logic        out_valid_reg, out_found_reg, out_rd_reg;
    logic [9:0]  out_row_reg, out_col_reg;
    logic [12:0] out_score_reg;

    logic [PW-1:0] ir, ic;
    logic [LW-1:0] lr, lc;

    logic img_mem [IMG_DEPTH];
    logic logo_mem [LOGO_DEPTH];
    logic img_q, logo_q;

    logic                img_we, logo_we, img_wd;
    logic [IMG_AW-1:0]   img_wa, img_ra;
    logic [LOGO_AW-1:0]  logo_wa, logo_ra;
    logic [PW-1:0]       rd_row, rd_col;

    always_comb
    begin
        if (image_rows_reg == 11'd0)
            ir = PW'(1);
        else if (PW'(image_rows_reg) > PW'(MAX_IMAGE_ROWS))
            ir = PW'(MAX_IMAGE_ROWS);
        else
            ir = PW'(image_rows_reg);
        if (image_cols_reg == 11'd0)
            ic = PW'(1);
        else if (PW'(image_cols_reg) > PW'(MAX_IMAGE_COLS))
            ic = PW'(MAX_IMAGE_COLS);
        else
            ic = PW'(image_cols_reg);
        if (logo_rows_reg == 7'd0)
            lr = LW'(1);
        else if (LW'(logo_rows_reg) > LW'(MAX_LOGO_ROWS))
            lr = LW'(MAX_LOGO_ROWS);
        else
            lr = LW'(logo_rows_reg);
        if (logo_ncols_reg == 7'd0)
            lc = LW'(1);
        else if (LW'(logo_ncols_reg) > LW'(MAX_LOGO_COLS))
            lc = LW'(MAX_LOGO_COLS);
        else
            lc = LW'(logo_ncols_reg);
    end

    // image address: pixel in EXEC, position + offset when scoring, else best match + offset
    always_comb
    begin
        if (state_reg == ST_EXEC)
        begin
            rd_row = PW'(pr_reg);
            rd_col = PW'(pc_reg);
        end
        else if (state_reg == ST_SC_RD)
        begin
            rd_row = r_reg + PW'(li_reg);
            rd_col = c_reg + PW'(lj_reg);
        end
        else
        begin
            rd_row = PW'(brow_reg) + PW'(li_reg);
            rd_col = PW'(bcol_reg) + PW'(lj_reg);
        end
        img_ra  = IMG_AW'(rd_row) * IMG_AW'(MAX_IMAGE_COLS) + IMG_AW'(rd_col);
        logo_ra = LOGO_AW'(li_reg) * LOGO_AW'(MAX_LOGO_COLS) + LOGO_AW'(lj_reg);
        img_wa  = img_ra;
        img_wd  = 1'b0;
        img_we  = 1'b0;
        logo_wa = LOGO_AW'(pr_reg) * LOGO_AW'(MAX_LOGO_COLS) + LOGO_AW'(pc_reg);
        logo_we = 1'b0;
        if (state_reg == ST_EXEC && req_reg == btm_pkg::REQ_WR_IMAGE
            && PW'(pr_reg) < ir && PW'(pc_reg) < ic)
        begin
            img_we = 1'b1;
            img_wa = img_ra;
            img_wd = pv_reg;
        end
        else if (state_reg == ST_RM_WR)
        begin
            img_we = 1'b1;
            img_wa = img_ra;
            img_wd = removal_mode_reg ? (img_q ^ logo_q) : 1'b0;
        end
        if (state_reg == ST_EXEC && req_reg == btm_pkg::REQ_WR_LOGO
            && PW'(pr_reg) < PW'(lr) && PW'(pc_reg) < PW'(lc))
            logo_we = 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (img_we)
            img_mem[img_wa] <= img_wd;
        img_q <= img_mem[img_ra];
    end

    always_ff @(posedge clk)
    begin
        if (logo_we)
            logo_mem[logo_wa] <= pv_reg;
        logo_q <= logo_mem[logo_ra];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            image_rows_reg   <= btm_pkg::RST_IMAGE_ROWS;
            image_cols_reg   <= btm_pkg::RST_IMAGE_COLS;
            logo_rows_reg    <= btm_pkg::RST_LOGO_ROWS;
            logo_ncols_reg   <= btm_pkg::RST_LOGO_COLS;
            match_cutoff_reg <= btm_pkg::RST_MATCH_CUTOFF;
            stop_score_reg   <= btm_pkg::RST_GOOD_ENOUGH;
            removal_mode_reg <= 1'b0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                btm_pkg::REG_IMAGE_ROWS:   image_rows_reg   <= cfg_data[10:0];
                btm_pkg::REG_IMAGE_COLS:   image_cols_reg   <= cfg_data[10:0];
                btm_pkg::REG_LOGO_ROWS:    logo_rows_reg    <= cfg_data[6:0];
                btm_pkg::REG_LOGO_COLS:    logo_ncols_reg   <= cfg_data[6:0];
                btm_pkg::REG_MATCH_CUTOFF: match_cutoff_reg <= cfg_data;
                btm_pkg::REG_GOOD_ENOUGH:  stop_score_reg   <= cfg_data;
                btm_pkg::REG_REMOVAL_MODE: removal_mode_reg <= cfg_data[0];
                default: ;
            endcase
        end
    end

    assign in_stall = (state_reg != ST_IDLE);

    logic [SW-1:0] s_next;
    logic          last_pix;
    assign s_next   = s_reg + SW'(img_q ^ logo_q);
    assign last_pix = (li_reg == lr - LW'(1)) && (lj_reg == lc - LW'(1));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (out_valid_reg && !out_stall && state_reg != ST_DONE)
                out_valid_reg <= 1'b0;
            case (state_reg)
                ST_IDLE:
                begin
                    if (in_valid)
                    begin
                        req_reg  <= req_type;
                        pr_reg   <= pix_row;
                        pc_reg   <= pix_col;
                        pv_reg   <= pix_value;
                        r_reg    <= PW'(search_row);
                        c_reg    <= PW'(search_col);
                        sc_reg   <= PW'(search_col);
                        rend_reg <= PW'(search_row) + PW'(search_rows);
                        cend_reg <= PW'(search_col) + PW'(search_cols);
                        state_reg <= ST_EXEC;
                    end
                end
                ST_EXEC:
                begin
                    found_reg  <= 1'b0;
                    brow_reg   <= '0;
                    bcol_reg   <= '0;
                    rd_reg     <= 1'b0;
                    best_reg   <= '0;
                    rd_hit_reg <= PW'(pr_reg) < ir && PW'(pc_reg) < ic;
                    case (req_reg)
                        btm_pkg::REQ_SEARCH:
                        begin
                            best_reg <= match_cutoff_reg;
                            if (search_rows_zero_reg)
                                rend_reg <= r_reg + ir;
                            if (search_cols_zero_reg)
                                cend_reg <= c_reg + ic;
                            state_reg <= ST_POS;
                        end
                        btm_pkg::REQ_RD_IMAGE: state_reg <= ST_RD_WAIT;
                        default: state_reg <= ST_DONE;
                    endcase
                end
                ST_RD_WAIT:
                begin
                    rd_reg    <= rd_hit_reg & img_q;
                    state_reg <= ST_DONE;
                end
                ST_POS:
                begin
                    li_reg <= '0;
                    lj_reg <= '0;
                    s_reg  <= '0;
                    if (!(r_reg < rend_reg && r_reg + PW'(lr) <= ir
                          && best_reg > stop_score_reg))
                        state_reg <= found_reg ? ST_RM_RD : ST_DONE;
                    else if (!(c_reg < cend_reg && c_reg + PW'(lc) <= ic))
                    begin
                        r_reg <= r_reg + PW'(1);
                        c_reg <= sc_reg;
                    end
                    else
                        state_reg <= ST_SC_RD;
                end
                ST_SC_RD:
                    state_reg <= ST_SC_ACC;
                ST_SC_ACC:
                begin
                    s_reg <= s_next;
                    if (s_next >= best_reg)
                    begin
                        c_reg     <= c_reg + PW'(1);
                        state_reg <= ST_POS;
                    end
                    else if (last_pix)
                    begin
                        best_reg  <= s_next;
                        brow_reg  <= r_reg[9:0];
                        bcol_reg  <= c_reg[9:0];
                        found_reg <= 1'b1;
                        c_reg     <= c_reg + PW'(1);
                        state_reg <= ST_POS;
                    end
                    else
                    begin
                        if (lj_reg == lc - LW'(1))
                        begin
                            lj_reg <= '0;
                            li_reg <= li_reg + LW'(1);
                        end
                        else
                            lj_reg <= lj_reg + LW'(1);
                        state_reg <= ST_SC_RD;
                    end
                end
                ST_RM_RD:
                    state_reg <= ST_RM_WR;
                ST_RM_WR:
                begin
                    if (last_pix)
                        state_reg <= ST_DONE;
                    else
                    begin
                        if (lj_reg == lc - LW'(1))
                        begin
                            lj_reg <= '0;
                            li_reg <= li_reg + LW'(1);
                        end
                        else
                            lj_reg <= lj_reg + LW'(1);
                        state_reg <= ST_RM_RD;
                    end
                end
                ST_DONE:
                begin
                    if (!out_valid_reg || !out_stall)
                    begin
                        out_valid_reg <= 1'b1;
                        out_found_reg <= found_reg;
                        out_row_reg   <= brow_reg;
                        out_col_reg   <= bcol_reg;
                        out_score_reg <= best_reg;
                        out_rd_reg    <= rd_reg;
                        state_reg     <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    // zero counts mean the image size in use
    always_ff @(posedge clk)
    begin
        if (state_reg == ST_IDLE && in_valid)
        begin
            search_rows_zero_reg <= (search_rows == 11'd0);
            search_cols_zero_reg <= (search_cols == 11'd0);
        end
    end

    assign out_valid  = out_valid_reg;
    assign found      = out_found_reg;
    assign match_row  = out_row_reg;
    assign match_col  = out_col_reg;
    assign best_score = out_score_reg;
    assign read_pixel = out_rd_reg;

    a_accept_exec: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> (state_reg == ST_EXEC))
        else $error("accepted word did not enter execution");

    a_score_below_best: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SC_RD) |-> (s_reg < best_reg))
        else $error("scoring continued past running best");

    a_found_below_cutoff: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DONE && found_reg) |-> (best_reg < match_cutoff_reg))
        else $error("match reported at or above cutoff");

    a_done_to_out: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DONE && !(out_valid_reg && out_stall)) |=> out_valid_reg)
        else $error("finished word not presented");

endmodule
